FILE: rtl/bfa_pkg.sv
// Shared types, constants and helpers for the buddy frame allocator.
package bfa_pkg;

	localparam int LEVELS    = 11;
	localparam int PAGE_BITS = 12;

	localparam int IDX_W   = LEVELS + 1;
	localparam int ROW_W   = LEVELS;
	localparam int DEPTH_W = $clog2(LEVELS + 1);
	localparam int SPAN_W  = PAGE_BITS + LEVELS;
	localparam int ADDR_W  = 23;
	localparam int PAGES_W = 12;
	localparam int COUNT_W = 12;
	localparam int ABIT_W  = $clog2(ADDR_W);

	typedef enum logic [1:0] {
		NODE_FREE  = 2'd0,
		NODE_PART  = 2'd1,
		NODE_ALLOC = 2'd2,
		NODE_FULL  = 2'd3
	} node_t;

	typedef node_t [1:0] node_pair_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_ALLOC_FAIL = 2'd1,
		STAT_NOT_FOUND  = 2'd2
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROOT,
		ST_A_ENTER,
		ST_A_KIDS,
		ST_A_CHOOSE,
		ST_A_TGT,
		ST_A_RET,
		ST_A_POST,
		ST_F_ENTER,
		ST_F_OWN,
		ST_F_UP,
		ST_F_KIDS,
		ST_F_OWN2
	} walk_state_t;

	typedef struct packed {
		logic             rd_en;
		logic [ROW_W-1:0] rd_row;
		logic             wr_en;
		logic [ROW_W-1:0] wr_row;
		logic [1:0]       wr_be;
		node_pair_t       wr_data;
	} mem_req_t;

	typedef struct packed {
		logic              valid;
		op_t               mode;
		logic              ok;
		status_t           status;
		logic [ADDR_W-1:0] addr;
	} walk_res_t;

	// Depth of the smallest block that still holds the request.
	function automatic logic [DEPTH_W-1:0] target_depth(input logic [PAGES_W-1:0] pages);
		logic [DEPTH_W-1:0] t;
		t = DEPTH_W'(LEVELS);
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (32'(pages) > (32'd1 << (LEVELS - i - 1)))
				t = DEPTH_W'(i);
		end
		return t;
	endfunction

	// Byte address of the first page covered by a node.
	function automatic logic [ADDR_W-1:0] block_base(input logic [IDX_W-1:0] idx,
		input logic [DEPTH_W-1:0] d);
		logic [IDX_W-1:0]  pos;
		logic [SPAN_W-1:0] wide;
		pos  = idx & ~({IDX_W{1'b1}} << d);
		wide = SPAN_W'(pos) << (SPAN_W - 32'(d));
		return ADDR_W'(wide);
	endfunction

endpackage

FILE: rtl/bfa_node_ram.sv
// Synchronous node-state RAM: one read port, one lane-masked write port.
module bfa_node_ram #(
	parameter int ADDR_W = 11,
	parameter int LANE_W = 2,
	parameter int LANES  = 2
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [ADDR_W-1:0]            rd_addr,
	output logic [LANES-1:0][LANE_W-1:0] rd_data,
	input  logic                         wr_en,
	input  logic [ADDR_W-1:0]            wr_addr,
	input  logic [LANES-1:0]             wr_be,
	input  logic [LANES-1:0][LANE_W-1:0] wr_data
);

	logic [LANES-1:0][LANE_W-1:0] mem [2**ADDR_W];
	logic [LANES-1:0][LANE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int l = 0; l < LANES; l++) begin
				if (wr_be[l])
					mem[wr_addr][l] <= wr_data[l];
			end
		end
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/bfa_walker.sv
// Tree walk sequencer: clearing pass, allocate search with backtracking, free and merge.
module bfa_walker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        mode,
	input  logic [bfa_pkg::PAGES_W-1:0] page_count,
	input  logic [bfa_pkg::ADDR_W-1:0]  block_address,
	output logic                        busy,
	output bfa_pkg::mem_req_t           mem,
	input  bfa_pkg::node_pair_t         rd_data,
	output bfa_pkg::walk_res_t          res
);

	localparam int IW = bfa_pkg::IDX_W;
	localparam int RW = bfa_pkg::ROW_W;
	localparam int DW = bfa_pkg::DEPTH_W;
	localparam int AW = bfa_pkg::ADDR_W;

	bfa_pkg::walk_state_t state_q, state_d;
	logic [IW-1:0]        idx_q, idx_d;
	logic [DW-1:0]        d_q, d_d;
	logic [DW-1:0]        tdepth_q, tdepth_d;
	logic                 side_q, side_d;
	logic                 ret_q, ret_d;
	bfa_pkg::node_pair_t  pair_q, pair_d;
	logic [AW-1:0]        grant_q, grant_d;
	logic [AW-1:0]        addr_q, addr_d;
	logic [RW-1:0]        clr_q, clr_d;
	bfa_pkg::node_t       own;
	logic                 aligned;
	logic [bfa_pkg::ABIT_W-1:0] bit_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		d_q      <= d_d;
		tdepth_q <= tdepth_d;
		side_q   <= side_d;
		ret_q    <= ret_d;
		pair_q   <= pair_d;
		grant_q  <= grant_d;
		addr_q   <= addr_d;
	end

	assign own     = rd_data[idx_q[0]];
	assign aligned = (addr_q & ~({AW{1'b1}} << (bfa_pkg::SPAN_W - 32'(d_q)))) == '0;
	assign bit_idx = bfa_pkg::ABIT_W'(bfa_pkg::SPAN_W - 1 - 32'(d_q));

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		d_d      = d_q;
		tdepth_d = tdepth_q;
		side_d   = side_q;
		ret_d    = ret_q;
		pair_d   = pair_q;
		grant_d  = grant_q;
		addr_d   = addr_q;
		clr_d    = clr_q;
		mem      = '0;
		res      = '0;
		busy     = 1'b1;
		case (state_q)
			bfa_pkg::ST_CLEAR: begin
				mem.wr_en   = 1'b1;
				mem.wr_row  = clr_q;
				mem.wr_be   = 2'b11;
				mem.wr_data = {bfa_pkg::NODE_FREE, bfa_pkg::NODE_FREE};
				clr_d       = clr_q + 1'b1;
				if (clr_q == '1)
					state_d = bfa_pkg::ST_IDLE;
			end
			bfa_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					addr_d   = block_address;
					tdepth_d = bfa_pkg::target_depth(page_count);
					idx_d    = IW'(1);
					d_d      = '0;
					if (mode == bfa_pkg::OP_FREE) begin
						state_d = bfa_pkg::ST_F_ENTER;
					end else if (page_count == '0 ||
						32'(page_count) > (32'd1 << bfa_pkg::LEVELS)) begin
						// Answer a bad page count from the return step at the root.
						ret_d   = 1'b0;
						state_d = bfa_pkg::ST_A_RET;
					end else begin
						mem.rd_en  = 1'b1;
						mem.rd_row = '0;
						state_d    = bfa_pkg::ST_ROOT;
					end
				end
			end
			bfa_pkg::ST_ROOT: begin
				if (rd_data[1] >= bfa_pkg::NODE_ALLOC) begin
					res.valid  = 1'b1;
					res.mode   = bfa_pkg::OP_ALLOC;
					res.status = bfa_pkg::STAT_ALLOC_FAIL;
					state_d    = bfa_pkg::ST_IDLE;
				end else begin
					state_d = bfa_pkg::ST_A_ENTER;
				end
			end
			bfa_pkg::ST_A_ENTER: begin
				mem.rd_en = 1'b1;
				if (d_q == tdepth_q) begin
					mem.rd_row = idx_q[IW-1:1];
					state_d    = bfa_pkg::ST_A_TGT;
				end else begin
					mem.rd_row = idx_q[RW-1:0];
					side_d     = 1'b0;
					state_d    = bfa_pkg::ST_A_KIDS;
				end
			end
			bfa_pkg::ST_A_KIDS: begin
				pair_d  = rd_data;
				state_d = bfa_pkg::ST_A_CHOOSE;
			end
			bfa_pkg::ST_A_CHOOSE: begin
				if (pair_q[side_q] <= bfa_pkg::NODE_PART) begin
					idx_d   = {idx_q[IW-2:0], side_q};
					d_d     = d_q + 1'b1;
					state_d = bfa_pkg::ST_A_ENTER;
				end else if (!side_q) begin
					side_d = 1'b1;
				end else begin
					ret_d   = 1'b0;
					state_d = bfa_pkg::ST_A_RET;
				end
			end
			bfa_pkg::ST_A_TGT: begin
				if (own == bfa_pkg::NODE_PART) begin
					ret_d = 1'b0;
				end else begin
					mem.wr_en   = 1'b1;
					mem.wr_row  = idx_q[IW-1:1];
					mem.wr_be   = 2'b01 << idx_q[0];
					mem.wr_data = {bfa_pkg::NODE_ALLOC, bfa_pkg::NODE_ALLOC};
					ret_d       = 1'b1;
					grant_d     = bfa_pkg::block_base(idx_q, d_q);
				end
				state_d = bfa_pkg::ST_A_RET;
			end
			bfa_pkg::ST_A_RET: begin
				if (d_q == '0) begin
					res.valid  = 1'b1;
					res.mode   = bfa_pkg::OP_ALLOC;
					res.ok     = ret_q;
					res.status = ret_q ? bfa_pkg::STAT_OK : bfa_pkg::STAT_ALLOC_FAIL;
					res.addr   = ret_q ? grant_q : '0;
					state_d    = bfa_pkg::ST_IDLE;
				end else begin
					side_d     = idx_q[0];
					idx_d      = idx_q >> 1;
					d_d        = d_q - 1'b1;
					mem.rd_en  = 1'b1;
					mem.rd_row = idx_q[IW-1:1];
					state_d    = bfa_pkg::ST_A_POST;
				end
			end
			bfa_pkg::ST_A_POST: begin
				pair_d     = rd_data;
				mem.wr_row = idx_q[IW-1:1];
				mem.wr_be  = 2'b01 << idx_q[0];
				if (rd_data[0] >= bfa_pkg::NODE_ALLOC && rd_data[1] >= bfa_pkg::NODE_ALLOC) begin
					mem.wr_en   = 1'b1;
					mem.wr_data = {bfa_pkg::NODE_FULL, bfa_pkg::NODE_FULL};
					state_d     = bfa_pkg::ST_A_RET;
				end else if (ret_q) begin
					mem.wr_en   = 1'b1;
					mem.wr_data = {bfa_pkg::NODE_PART, bfa_pkg::NODE_PART};
					state_d     = bfa_pkg::ST_A_RET;
				end else if (!side_q) begin
					side_d  = 1'b1;
					state_d = bfa_pkg::ST_A_CHOOSE;
				end else begin
					state_d = bfa_pkg::ST_A_RET;
				end
			end
			bfa_pkg::ST_F_ENTER: begin
				mem.rd_en  = 1'b1;
				mem.rd_row = idx_q[IW-1:1];
				state_d    = bfa_pkg::ST_F_OWN;
			end
			bfa_pkg::ST_F_OWN: begin
				if (aligned && own == bfa_pkg::NODE_ALLOC) begin
					mem.wr_en   = 1'b1;
					mem.wr_row  = idx_q[IW-1:1];
					mem.wr_be   = 2'b01 << idx_q[0];
					mem.wr_data = {bfa_pkg::NODE_FREE, bfa_pkg::NODE_FREE};
					state_d     = bfa_pkg::ST_F_UP;
				end else if (d_q == DW'(bfa_pkg::LEVELS)) begin
					res.valid  = 1'b1;
					res.mode   = bfa_pkg::OP_FREE;
					res.status = bfa_pkg::STAT_NOT_FOUND;
					state_d    = bfa_pkg::ST_IDLE;
				end else begin
					idx_d   = {idx_q[IW-2:0], addr_q[bit_idx]};
					d_d     = d_q + 1'b1;
					state_d = bfa_pkg::ST_F_ENTER;
				end
			end
			bfa_pkg::ST_F_UP: begin
				if (d_q == '0) begin
					res.valid  = 1'b1;
					res.mode   = bfa_pkg::OP_FREE;
					res.ok     = 1'b1;
					res.status = bfa_pkg::STAT_OK;
					state_d    = bfa_pkg::ST_IDLE;
				end else begin
					idx_d      = idx_q >> 1;
					d_d        = d_q - 1'b1;
					mem.rd_en  = 1'b1;
					mem.rd_row = idx_q[IW-1:1];
					state_d    = bfa_pkg::ST_F_KIDS;
				end
			end
			bfa_pkg::ST_F_KIDS: begin
				pair_d     = rd_data;
				mem.rd_en  = 1'b1;
				mem.rd_row = idx_q[IW-1:1];
				state_d    = bfa_pkg::ST_F_OWN2;
			end
			bfa_pkg::ST_F_OWN2: begin
				mem.wr_row = idx_q[IW-1:1];
				mem.wr_be  = 2'b01 << idx_q[0];
				if (pair_q[0] == bfa_pkg::NODE_FREE && pair_q[1] == bfa_pkg::NODE_FREE) begin
					mem.wr_en   = 1'b1;
					mem.wr_data = {bfa_pkg::NODE_FREE, bfa_pkg::NODE_FREE};
				end else if (own == bfa_pkg::NODE_FULL) begin
					mem.wr_en   = 1'b1;
					mem.wr_data = {bfa_pkg::NODE_PART, bfa_pkg::NODE_PART};
				end
				state_d = bfa_pkg::ST_F_UP;
			end
			default: begin
				state_d = bfa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/buddy_frame_allocator.sv
// Top level of the buddy frame allocator: node RAM, tree walker, result and count registers.
// Allocate: root check, descent level by level to the target depth, target read and mark,
//   final step, plus backtracking over every subtree tried and abandoned; a bad count skips
//   the search. Free: descent to the owning node, then a climb to the root merging siblings.
// The result strobe is registered from the walk; a new transaction is taken once busy drops.
// After reset a clearing pass zeroes all 2048 node RAM rows with busy held high.
module buddy_frame_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        mode,
	input  logic [bfa_pkg::PAGES_W-1:0] page_count,
	input  logic [bfa_pkg::ADDR_W-1:0]  block_address,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [bfa_pkg::ADDR_W-1:0]  granted_address,
	output logic [bfa_pkg::COUNT_W-1:0] allocated_blocks
);

	bfa_pkg::mem_req_t   mem;
	bfa_pkg::node_pair_t rd_data;
	bfa_pkg::walk_res_t  res;

	logic                        done_q;
	bfa_pkg::status_t            status_q;
	logic [bfa_pkg::ADDR_W-1:0]  granted_q;
	logic [bfa_pkg::COUNT_W-1:0] count_q;

	// Node states, two siblings per row so a parent sees both children in one read.
	bfa_node_ram #(
		.ADDR_W (bfa_pkg::ROW_W),
		.LANE_W (2),
		.LANES  (2)
	) u_ram (
		.clk     (clk),
		.rd_en   (mem.rd_en),
		.rd_addr (mem.rd_row),
		.rd_data (rd_data),
		.wr_en   (mem.wr_en),
		.wr_addr (mem.wr_row),
		.wr_be   (mem.wr_be),
		.wr_data (mem.wr_data)
	);

	bfa_walker u_walker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.mode          (mode),
		.page_count    (page_count),
		.block_address (block_address),
		.busy          (busy),
		.mem           (mem),
		.rd_data       (rd_data),
		.res           (res)
	);

	// Strobe and running count of allocated blocks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= res.valid;
			if (res.valid && res.ok) begin
				if (res.mode == bfa_pkg::OP_FREE)
					count_q <= count_q - 1'b1;
				else
					count_q <= count_q + 1'b1;
			end
		end
	end

	// Hold the payload of the last transaction.
	always_ff @(posedge clk) begin
		if (res.valid) begin
			status_q  <= res.status;
			granted_q <= res.addr;
		end
	end

	assign done             = done_q;
	assign status           = status_q;
	assign granted_address  = granted_q;
	assign allocated_blocks = count_q;

endmodule

FILE: rtl/bfa_checker.sv
// Port-level assertions for the buddy frame allocator and their bind.
module bfa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [1:0]                  status,
	input logic [bfa_pkg::ADDR_W-1:0]  granted_address,
	input logic [bfa_pkg::COUNT_W-1:0] allocated_blocks
);

	// An accepted transaction keeps the block busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after accepting a transaction");

	// No result can come out in the cycle after acceptance.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result strobe one cycle after accept");

	// A failing transaction grants nothing.
	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != bfa_pkg::STAT_OK |-> granted_address == '0)
		else $error("nonzero address on a failed transaction");

	// The count only moves together with a result.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!done |=> (done || $stable(allocated_blocks)))
		else $error("allocated count changed without a result");

	// Strobes are single-cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

bind buddy_frame_allocator bfa_checker u_bfa_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.status           (status),
	.granted_address  (granted_address),
	.allocated_blocks (allocated_blocks)
);
